// ----- rtl/ile_pkg.sv -----
package ile_pkg;

    // Command modes
    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_FRONT  = 3'd1;
    localparam logic [2:0] MODE_BACK   = 3'd2;
    localparam logic [2:0] MODE_AT     = 3'd3;
    localparam logic [2:0] MODE_DELETE = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Sources for the latched position
    localparam logic [1:0] PSEL_INPUT = 2'd0;
    localparam logic [1:0] PSEL_FRONT = 2'd1;
    localparam logic [1:0] PSEL_BACK  = 2'd2;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                load;      // capture item, set pointer
        logic                ins;       // shift direction: insert opens, delete closes
        logic [1:0]          pos_sel;   // where the target position comes from
        logic                rd_en;     // read the shift source entry
        logic                rd_pos;    // read the entry at the target position
        logic                wr_shift;  // write moved entry, step pointer
        logic                wr_put;    // write new value, bump count
        logic                cnt_dec;   // drop one entry from the count
        logic                finish;    // load the result registers
        logic                use_mem;   // result value comes from the memory
        logic [STATUS_W-1:0] status;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pos_lt_cnt;  // incoming position below count
        logic pos_le_cnt;  // incoming position at most count
        logic full;        // list at capacity
        logic more;        // another entry to move
    } dp_stat_t;

endpackage

// ----- rtl/ile_ctrl.sv -----
module ile_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ile_pkg::MODE_W-1:0]      mode,
    input  ile_pkg::dp_stat_t               stat,
    output ile_pkg::ctl_cmd_t               cmd,
    output logic                            busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RREAD = 3'd1;
    localparam logic [2:0] S_SHRD  = 3'd2;
    localparam logic [2:0] S_SHWR  = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic                           ins_reg, ins_next;
    logic                           use_mem_reg, use_mem_next;
    logic [ile_pkg::STATUS_W-1:0]   status_reg, status_next;

    assign busy = (state_reg != S_IDLE);

    // Hold state and the per-item decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ins_reg     <= 1'b0;
            use_mem_reg <= 1'b0;
            status_reg  <= ile_pkg::ST_DONE;
        end
        else
        begin
            state_reg   <= state_next;
            ins_reg     <= ins_next;
            use_mem_reg <= use_mem_next;
            status_reg  <= status_next;
        end
    end

    // Decode the item, then sequence the shift
    always_comb
    begin
        state_next   = state_reg;
        ins_next     = ins_reg;
        use_mem_next = use_mem_reg;
        status_next  = status_reg;
        cmd          = '0;
        cmd.pos_sel  = ile_pkg::PSEL_INPUT;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    use_mem_next = 1'b0;
                    status_next  = ile_pkg::ST_DONE;
                    state_next   = S_FIN;
                    unique case (mode)
                        ile_pkg::MODE_READ:
                        begin
                            if (stat.pos_lt_cnt)
                            begin
                                cmd.load     = 1'b1;
                                use_mem_next = 1'b1;
                                state_next   = S_RREAD;
                            end
                            else
                                status_next = ile_pkg::ST_BADPOS;
                        end
                        ile_pkg::MODE_FRONT, ile_pkg::MODE_BACK:
                        begin
                            if (stat.full)
                                status_next = ile_pkg::ST_FULL;
                            else
                            begin
                                cmd.load    = 1'b1;
                                ins_next    = 1'b1;
                                cmd.pos_sel = (mode == ile_pkg::MODE_FRONT) ?
                                              ile_pkg::PSEL_FRONT : ile_pkg::PSEL_BACK;
                                state_next  = S_SHRD;
                            end
                        end
                        ile_pkg::MODE_AT:
                        begin
                            if (!stat.pos_le_cnt)
                                status_next = ile_pkg::ST_BADPOS;
                            else if (stat.full)
                                status_next = ile_pkg::ST_FULL;
                            else
                            begin
                                cmd.load   = 1'b1;
                                ins_next   = 1'b1;
                                state_next = S_SHRD;
                            end
                        end
                        ile_pkg::MODE_DELETE:
                        begin
                            if (stat.pos_lt_cnt)
                            begin
                                cmd.load   = 1'b1;
                                ins_next   = 1'b0;
                                state_next = S_SHRD;
                            end
                            else
                                status_next = ile_pkg::ST_BADPOS;
                        end
                        default:
                            status_next = ile_pkg::ST_BADPOS;
                    endcase
                end
            end
            S_RREAD:
            begin
                cmd.rd_pos = 1'b1;
                state_next = S_FIN;
            end
            S_SHRD:
            begin
                if (stat.more)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SHWR;
                end
                else if (ins_reg)
                    state_next = S_PUT;
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_SHWR:
            begin
                cmd.wr_shift = 1'b1;
                state_next   = S_SHRD;
            end
            S_PUT:
            begin
                cmd.wr_put = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase

        cmd.ins     = ins_next;
        cmd.use_mem = use_mem_reg;
        cmd.status  = status_reg;
    end

endmodule

// ----- rtl/ile_datapath.sv -----
module ile_datapath #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ile_pkg::ctl_cmd_t                   cmd,
    input  logic [ile_pkg::POS_W-1:0]           position,
    input  logic signed [ile_pkg::DATA_W-1:0]   new_value,
    output ile_pkg::dp_stat_t                   stat,
    output logic                                done,
    output logic signed [ile_pkg::DATA_W-1:0]   read_value,
    output logic [ile_pkg::STATUS_W-1:0]        status,
    output logic [ile_pkg::COUNT_W-1:0]         entry_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > ile_pkg::POS_W) ? CW : ile_pkg::POS_W;

    logic [ile_pkg::DATA_W-1:0]         mem [CAPACITY];
    logic [ile_pkg::DATA_W-1:0]         mem_q;

    logic [CW-1:0]                      count_reg;
    logic [AW-1:0]                      ptr_reg;
    logic [AW-1:0]                      pos_reg;
    logic [ile_pkg::DATA_W-1:0]         value_reg;

    logic                               done_reg;
    logic [ile_pkg::DATA_W-1:0]         read_value_reg;
    logic [ile_pkg::STATUS_W-1:0]       status_reg;
    logic [ile_pkg::COUNT_W-1:0]        entry_count_reg;

    logic [XW-1:0]                      pos_ext;
    logic [XW-1:0]                      cnt_ext;
    logic [AW-1:0]                      pos_sel;
    logic [AW-1:0]                      rd_addr;
    logic [AW-1:0]                      wr_addr;
    logic [ile_pkg::DATA_W-1:0]         wr_data;
    logic                               wr_en;

    // Classify the incoming position against the count
    assign pos_ext         = XW'(position);
    assign cnt_ext         = XW'(count_reg);
    assign stat.pos_lt_cnt = (pos_ext < cnt_ext);
    assign stat.pos_le_cnt = (pos_ext <= cnt_ext);
    assign stat.full       = (count_reg == CW'(CAPACITY));
    assign stat.more       = cmd.ins ? (ptr_reg > pos_reg)
                                     : ((CW'(ptr_reg) + CW'(1)) < count_reg);

    // Pick the target position for the item
    always_comb
    begin
        unique case (cmd.pos_sel)
            ile_pkg::PSEL_FRONT: pos_sel = '0;
            ile_pkg::PSEL_BACK:  pos_sel = count_reg[AW-1:0];
            default:             pos_sel = pos_ext[AW-1:0];
        endcase
    end

    // Address and data for the entry store
    assign rd_addr = cmd.rd_pos ? pos_reg :
                     (cmd.ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1)));
    assign wr_en   = cmd.wr_shift | cmd.wr_put;
    assign wr_addr = cmd.wr_put ? pos_reg : ptr_reg;
    assign wr_data = cmd.wr_put ? value_reg : mem_q;

    // Entry store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en || cmd.rd_pos)
            mem_q <= mem[rd_addr];
    end

    // Capture the item and walk the pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pos_reg   <= pos_sel;
            value_reg <= new_value;
            ptr_reg   <= cmd.ins ? count_reg[AW-1:0] : pos_sel;
        end
        else if (cmd.wr_shift)
            ptr_reg <= cmd.ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
    end

    // Track the number of entries in use
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.wr_put)
            count_reg <= count_reg + CW'(1);
        else if (cmd.cnt_dec)
            count_reg <= count_reg - CW'(1);
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            read_value_reg  <= cmd.use_mem ? mem_q : '1;
            status_reg      <= cmd.status;
            entry_count_reg <= cnt_ext[ile_pkg::COUNT_W-1:0];
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ----- rtl/indexed_list_engine.sv -----
// Channel   Ports                                   Handshake
// command   mode, position, new_value               start, taken when busy is low
// result    read_value, status, entry_count         done, one cycle, no back-pressure
//
// A rejected command goes straight to S_FIN; a read passes S_RREAD first.
// Each entry moved takes S_SHRD then S_SHWR: one registered read, then one write
// on the entry memory. An insert then writes the new value in S_PUT, a delete
// drops the count. busy stays high until the result is loaded.
// Reset clears the count and the controller; the entry memory is not cleared.
// The result strobe cannot be held off; a new command may be taken while done shows.
module indexed_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ile_pkg::MODE_W-1:0]          mode,
    input  logic [ile_pkg::POS_W-1:0]           position,
    input  logic signed [ile_pkg::DATA_W-1:0]   new_value,
    output logic                                done,
    output logic signed [ile_pkg::DATA_W-1:0]   read_value,
    output logic [ile_pkg::STATUS_W-1:0]        status,
    output logic [ile_pkg::COUNT_W-1:0]         entry_count
);

    ile_pkg::ctl_cmd_t  cmd;
    ile_pkg::dp_stat_t  stat;
    logic               start_ok;

    assign start_ok = start & ~busy;

    // Sequence each item
    ile_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .mode  (mode),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Store entries and build results
    ile_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .position    (position),
        .new_value   (new_value),
        .stat        (stat),
        .done        (done),
        .read_value  (read_value),
        .status      (status),
        .entry_count (entry_count)
    );

endmodule

// ----- rtl/ile_checker.sv -----
module ile_checker #(
    parameter int CAPACITY = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic [ile_pkg::MODE_W-1:0]          mode,
    input  logic [ile_pkg::POS_W-1:0]           position,
    input  logic signed [ile_pkg::DATA_W-1:0]   new_value,
    input  logic                                done,
    input  logic signed [ile_pkg::DATA_W-1:0]   read_value,
    input  logic [ile_pkg::STATUS_W-1:0]        status,
    input  logic [ile_pkg::COUNT_W-1:0]         entry_count
);

    // Every accepted item occupies the engine
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // A result only shows once the engine is free
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // One strobe per item
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // A dropped insert means the list is at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == ile_pkg::ST_FULL) |-> (entry_count == ile_pkg::COUNT_W'(CAPACITY)))
        else $error("full status with list not at capacity");

    // A rejected item carries a value of all ones
    a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ile_pkg::ST_DONE) |-> (read_value == '1))
        else $error("rejected item returned a value");

endmodule

bind indexed_list_engine ile_checker #(.CAPACITY(CAPACITY)) u_ile_checker (.*);
